[rtl/aht_pkg.sv]
// Shared types, constants and the request token of the ARP host table learner.
`timescale 1ns / 1ps

package aht_pkg;

    // Table size and the widths that follow from it.
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Fixed field widths of the ports.
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int FLAG_W  = 3;
    localparam int IDX_W   = 6;
    localparam int OSLOT_W = 6;
    localparam int OCNT_W  = 7;
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [IP_W-1:0]    t_ip;
    typedef logic [MAC_W-1:0]   t_mac;
    typedef logic [FLAG_W-1:0]  t_flags;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [OSLOT_W-1:0] t_oslot;
    typedef logic [OCNT_W-1:0]  t_ocnt;
    typedef logic [CMP_W-1:0]   t_cmp;

    localparam t_cnt FULL_CNT = t_cnt'(TABLE_ENTRIES);

    // Request kinds on the input channel.
    localparam logic KIND_READ = 1'b1;

    // Event flag bits of an entry.
    localparam t_flags FLAG_GRAT = 3'b001;
    localparam t_flags FLAG_SEND = 3'b010;
    localparam t_flags FLAG_TARG = 3'b100;

    // What a token does as it passes the cells.
    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_READ,
        OP_WRITE
    } t_op;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic   vld;
        t_op    op;
        t_slot  pos;
        t_cnt   cnt;
        t_ip    sip;
        t_ip    tip;
        t_mac   smac;
        t_mac   tmac;
        logic   grat;
        // Read request and its returned entry.
        logic   rd_ok;
        t_slot  rd_slot;
        t_ip    ent_ip;
        t_mac   ent_mac;
        t_flags ent_flags;
        // Lookup results.
        logic   s_found;
        t_slot  s_slot;
        logic   t_found;
        t_slot  tgt_slot;
        // Write commands.
        logic   s_upd;
        logic   t_upd;
        logic   flag_en;
        logic   ins_s_en;
        t_slot  ins_s_slot;
        t_mac   ins_s_mac;
        t_flags ins_s_flags;
        logic   ins_t_en;
        t_slot  ins_t_slot;
    } t_tok;

    // One result item.
    typedef struct packed {
        t_oslot sender_slot;
        t_oslot target_slot;
        logic   sender_was_new;
        logic   target_was_new;
        logic   entry_added;
        logic   table_full;
        t_ip    entry_ip;
        t_mac   entry_mac;
        t_flags entry_flags;
        t_ocnt  entry_count;
    } t_res;

endpackage

[rtl/aht_cell.sv]
// One table cell: holds one host entry and passes the token to the next cell.
`timescale 1ns / 1ps

module aht_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aht_pkg::t_tok i_tok,
    output aht_pkg::t_tok o_tok
);

    aht_pkg::t_ip    r_ip;
    aht_pkg::t_mac   r_mac;
    aht_pkg::t_flags r_flags;
    aht_pkg::t_tok   r_tok;

    aht_pkg::t_ip    n_ip;
    aht_pkg::t_mac   n_mac;
    aht_pkg::t_flags n_flags;
    aht_pkg::t_tok   n_tok;

    logic          in_tbl;
    logic          s_hit;
    logic          t_hit;
    aht_pkg::t_mac mac_s;

    // The token's position counter is this cell's slot number.
    assign in_tbl = aht_pkg::t_cnt'(i_tok.pos) < i_tok.cnt;
    assign s_hit  = i_tok.s_upd && (i_tok.s_slot == i_tok.pos);
    assign t_hit  = i_tok.t_upd && (i_tok.tgt_slot == i_tok.pos);

    // A zero MAC takes the sender MAC first, then the target MAC.
    assign mac_s = (s_hit && (r_mac == '0) && (i_tok.smac != '0)) ? i_tok.smac : r_mac;

    // Compare, read out or update this entry as the token passes.
    always_comb begin
        n_tok     = i_tok;
        n_tok.pos = i_tok.pos + 1'b1;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_flags   = r_flags;
        if (i_tok.vld) begin
            case (i_tok.op)
                aht_pkg::OP_LOOKUP: begin
                    if (in_tbl && (r_ip == i_tok.sip)) begin
                        n_tok.s_found = 1'b1;
                        n_tok.s_slot  = i_tok.pos;
                    end
                    if (in_tbl && (r_ip == i_tok.tip)) begin
                        n_tok.t_found  = 1'b1;
                        n_tok.tgt_slot = i_tok.pos;
                    end
                end
                aht_pkg::OP_READ: begin
                    if (in_tbl && (i_tok.rd_slot == i_tok.pos)) begin
                        n_tok.ent_ip    = r_ip;
                        n_tok.ent_mac   = r_mac;
                        n_tok.ent_flags = r_flags;
                    end
                end
                aht_pkg::OP_WRITE: begin
                    n_mac = (t_hit && (mac_s == '0) && (i_tok.tmac != '0)) ? i_tok.tmac : mac_s;
                    if (i_tok.flag_en && s_hit) begin
                        n_flags = r_flags | (i_tok.grat ? aht_pkg::FLAG_GRAT
                                                        : aht_pkg::FLAG_SEND);
                    end else if (i_tok.flag_en && t_hit) begin
                        n_flags = r_flags | aht_pkg::FLAG_TARG;
                    end
                    if (i_tok.ins_s_en && (i_tok.ins_s_slot == i_tok.pos)) begin
                        n_ip    = i_tok.sip;
                        n_mac   = i_tok.ins_s_mac;
                        n_flags = i_tok.ins_s_flags;
                    end
                    if (i_tok.ins_t_en && (i_tok.ins_t_slot == i_tok.pos)) begin
                        n_ip    = i_tok.tip;
                        n_mac   = i_tok.tmac;
                        n_flags = aht_pkg::FLAG_TARG;
                    end
                end
                default: begin
                    n_tok.vld = 1'b0;
                end
            endcase
        end
        // Reset clears the token in flight.
        if (!i_rst_n) begin
            n_tok.vld = 1'b0;
        end
    end

    // Entry storage; written only by a write token.
    always_ff @(posedge i_clk) begin
        r_ip    <= n_ip;
        r_mac   <= n_mac;
        r_flags <= n_flags;
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

[rtl/aht_ctrl.sv]
// Sequencer: launches lookup and write tokens, decides inserts, holds the result.
`timescale 1ns / 1ps

module aht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_kind,
    input  aht_pkg::t_ip    i_sender_ip,
    input  aht_pkg::t_ip    i_target_ip,
    input  aht_pkg::t_mac   i_sender_mac,
    input  aht_pkg::t_mac   i_target_mac,
    input  aht_pkg::t_idx   i_read_index,
    output aht_pkg::t_tok   o_tok,
    input  aht_pkg::t_tok   i_tok,
    output logic            o_valid,
    input  logic            i_stall,
    output aht_pkg::t_res   o_res
);

    aht_pkg::t_state r_state;
    aht_pkg::t_state n_state;
    aht_pkg::t_tok   r_tok;
    aht_pkg::t_tok   n_tok;
    aht_pkg::t_cnt   r_count;
    aht_pkg::t_cnt   n_count;
    aht_pkg::t_res   r_res;
    aht_pkg::t_res   n_res;
    aht_pkg::t_res   r_out;
    aht_pkg::t_res   n_out;
    logic            r_out_vld;
    logic            n_out_vld;

    // Decision after the lookup pass.
    logic            eq;
    logic            grat;
    logic            room0;
    logic            room1;
    aht_pkg::t_cnt   cnt1;
    aht_pkg::t_cnt   cnt2;
    aht_pkg::t_slot  s_slot_o;
    aht_pkg::t_slot  t_slot_o;
    logic            s_new;
    logic            t_new;
    logic            full;
    aht_pkg::t_tok   wr_tok;
    aht_pkg::t_cnt   wr_count;
    aht_pkg::t_res   wr_res;
    aht_pkg::t_res   rd_res;

    assign eq    = i_tok.sip == i_tok.tip;
    assign grat  = eq && (i_tok.tmac == '0);
    assign cnt1  = r_count + 1'b1;
    assign cnt2  = cnt1 + 1'b1;
    assign room0 = r_count != aht_pkg::FULL_CNT;
    assign room1 = room0 && (cnt1 != aht_pkg::FULL_CNT);

    // Sender first, then target; inserts go to the next free slots in order.
    always_comb begin
        wr_tok             = i_tok;
        wr_tok.vld         = 1'b1;
        wr_tok.op          = aht_pkg::OP_WRITE;
        wr_tok.pos         = '0;
        wr_tok.grat        = grat;
        wr_tok.s_upd       = 1'b0;
        wr_tok.t_upd       = 1'b0;
        wr_tok.flag_en     = 1'b0;
        wr_tok.ins_s_en    = 1'b0;
        wr_tok.ins_s_slot  = aht_pkg::t_slot'(r_count);
        wr_tok.ins_s_mac   = (eq && (i_tok.smac == '0)) ? i_tok.tmac : i_tok.smac;
        wr_tok.ins_s_flags = grat ? aht_pkg::FLAG_GRAT : aht_pkg::FLAG_SEND;
        wr_tok.ins_t_en    = 1'b0;
        wr_tok.ins_t_slot  = aht_pkg::t_slot'(r_count);
        wr_count           = r_count;
        s_slot_o           = '0;
        t_slot_o           = '0;
        s_new              = 1'b0;
        t_new              = 1'b0;
        full               = 1'b0;
        if (i_tok.s_found) begin
            wr_tok.s_upd = 1'b1;
            s_slot_o     = i_tok.s_slot;
            if (i_tok.t_found) begin
                wr_tok.t_upd   = 1'b1;
                wr_tok.flag_en = 1'b1;
                t_slot_o       = i_tok.tgt_slot;
            end else if (room0) begin
                wr_tok.ins_t_en = 1'b1;
                t_new           = 1'b1;
                t_slot_o        = aht_pkg::t_slot'(r_count);
                wr_count        = cnt1;
            end else begin
                full = 1'b1;
            end
        end else if (room0) begin
            wr_tok.ins_s_en = 1'b1;
            s_new           = 1'b1;
            s_slot_o        = aht_pkg::t_slot'(r_count);
            wr_count        = cnt1;
            if (eq) begin
                // The target lookup finds the entry just added.
                t_slot_o = aht_pkg::t_slot'(r_count);
            end else if (i_tok.t_found) begin
                wr_tok.t_upd = 1'b1;
                t_slot_o     = i_tok.tgt_slot;
            end else if (room1) begin
                wr_tok.ins_t_en   = 1'b1;
                wr_tok.ins_t_slot = aht_pkg::t_slot'(cnt1);
                t_new             = 1'b1;
                t_slot_o          = aht_pkg::t_slot'(cnt1);
                wr_count          = cnt2;
            end else begin
                full = 1'b1;
            end
        end else begin
            full = 1'b1;
            if (!eq && i_tok.t_found) begin
                wr_tok.t_upd = 1'b1;
                t_slot_o     = i_tok.tgt_slot;
            end
        end
    end

    // Result of a packet request.
    always_comb begin
        wr_res                = '0;
        wr_res.sender_slot    = aht_pkg::t_oslot'(s_slot_o);
        wr_res.target_slot    = aht_pkg::t_oslot'(t_slot_o);
        wr_res.sender_was_new = s_new;
        wr_res.target_was_new = t_new;
        wr_res.entry_added    = s_new || t_new;
        wr_res.table_full     = full;
        wr_res.entry_count    = aht_pkg::t_ocnt'(wr_count);
    end

    // Result of a read request.
    always_comb begin
        rd_res             = '0;
        rd_res.entry_count = aht_pkg::t_ocnt'(r_count);
        if (i_tok.rd_ok) begin
            rd_res.entry_ip    = i_tok.ent_ip;
            rd_res.entry_mac   = i_tok.ent_mac;
            rd_res.entry_flags = i_tok.ent_flags;
        end
    end

    // Next state and outputs.
    always_comb begin
        n_state   = r_state;
        n_tok     = r_tok;
        n_tok.vld = 1'b0;
        n_count   = r_count;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            aht_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_tok         = '0;
                    n_tok.vld     = 1'b1;
                    n_tok.op      = (i_kind == aht_pkg::KIND_READ) ? aht_pkg::OP_READ
                                                                   : aht_pkg::OP_LOOKUP;
                    n_tok.cnt     = r_count;
                    n_tok.sip     = i_sender_ip;
                    n_tok.tip     = i_target_ip;
                    n_tok.smac    = i_sender_mac;
                    n_tok.tmac    = i_target_mac;
                    n_tok.rd_slot = aht_pkg::t_slot'(i_read_index);
                    n_tok.rd_ok   = aht_pkg::t_cmp'(i_read_index) < aht_pkg::t_cmp'(r_count);
                    n_state       = aht_pkg::ST_LOOK;
                end
            end
            aht_pkg::ST_LOOK: begin
                if (i_tok.vld) begin
                    if (i_tok.op == aht_pkg::OP_READ) begin
                        n_res   = rd_res;
                        n_state = aht_pkg::ST_DONE;
                    end else begin
                        n_tok   = wr_tok;
                        n_count = wr_count;
                        n_res   = wr_res;
                        n_state = aht_pkg::ST_WRITE;
                    end
                end
            end
            aht_pkg::ST_WRITE: begin
                if (i_tok.vld) begin
                    n_state = aht_pkg::ST_DONE;
                end
            end
            aht_pkg::ST_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = aht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aht_pkg::ST_IDLE;
            end
        endcase
        // Reset launches no token.
        if (!i_rst_n) begin
            n_tok.vld = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= aht_pkg::ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // Token launch register and result payloads.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_stall = r_state != aht_pkg::ST_IDLE;
    assign o_tok   = r_tok;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

[rtl/arp_host_table_learner_unit.sv]
// Top level of the ARP host table learner: sequencer and the row of table cells.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | i_valid / o_stall  | i_kind, IPs, MACs, i_read_index
//  result   | out       | o_valid / i_stall  | slots, new/added/full flags, entry, count
//
// A request token walks the row of TABLE_ENTRIES cells, one cell per cycle.
// A packet takes two walks (lookup, then write).
// A read takes one walk.
// Reset empties the table at once; entries past the fill count are never looked at.
// The result waits in an output register; a stalled result only delays the next one.
`timescale 1ns / 1ps

module arp_host_table_learner_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [31:0]           i_sender_ip,
    input  logic [31:0]           i_target_ip,
    input  logic [47:0]           i_sender_mac,
    input  logic [47:0]           i_target_mac,
    input  logic [5:0]            i_read_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [5:0]            o_sender_slot,
    output logic [5:0]            o_target_slot,
    output logic                  o_sender_was_new,
    output logic                  o_target_was_new,
    output logic                  o_entry_added,
    output logic                  o_table_full,
    output logic [31:0]           o_entry_ip,
    output logic [47:0]           o_entry_mac,
    output logic                  o_entry_gratuitous,
    output logic                  o_entry_sender_flag,
    output logic                  o_entry_target_flag,
    output logic [6:0]            o_entry_count
);

    aht_pkg::t_tok chain [0:aht_pkg::TABLE_ENTRIES];
    aht_pkg::t_res res;

    // Sequencer.
    aht_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_sender_ip  (i_sender_ip),
        .i_target_ip  (i_target_ip),
        .i_sender_mac (i_sender_mac),
        .i_target_mac (i_target_mac),
        .i_read_index (i_read_index),
        .o_tok        (chain[0]),
        .i_tok        (chain[aht_pkg::TABLE_ENTRIES]),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res        (res)
    );

    // Row of table cells; each hands the token to its neighbor.
    for (genvar g = 0; g < aht_pkg::TABLE_ENTRIES; g++) begin : g_cell
        aht_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    // Result fields.
    assign o_sender_slot       = res.sender_slot;
    assign o_target_slot       = res.target_slot;
    assign o_sender_was_new    = res.sender_was_new;
    assign o_target_was_new    = res.target_was_new;
    assign o_entry_added       = res.entry_added;
    assign o_table_full        = res.table_full;
    assign o_entry_ip          = res.entry_ip;
    assign o_entry_mac         = res.entry_mac;
    assign o_entry_gratuitous  = res.entry_flags[0];
    assign o_entry_sender_flag = res.entry_flags[1];
    assign o_entry_target_flag = res.entry_flags[2];
    assign o_entry_count       = res.entry_count;

endmodule

[rtl/aht_checker.sv]
// Port-level checks of the ARP host table learner, bound to the top level.
`timescale 1ns / 1ps

module aht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_kind,
    input logic [31:0] i_sender_ip,
    input logic [31:0] i_target_ip,
    input logic [47:0] i_sender_mac,
    input logic [47:0] i_target_mac,
    input logic [5:0]  i_read_index,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_sender_slot,
    input logic [5:0]  o_target_slot,
    input logic        o_sender_was_new,
    input logic        o_target_was_new,
    input logic        o_entry_added,
    input logic        o_table_full,
    input logic [31:0] o_entry_ip,
    input logic [47:0] o_entry_mac,
    input logic        o_entry_gratuitous,
    input logic        o_entry_sender_flag,
    input logic        o_entry_target_flag,
    input logic [6:0]  o_entry_count
);

    // A held result keeps its slots and count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sender_slot)
            && $stable(o_target_slot) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // One request at a time: an accepted request blocks the next cycle.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted while busy");

    // The added flag agrees with the two new flags.
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_added == (o_sender_was_new || o_target_was_new)))
        else $error("entry_added disagrees with new flags");

    // The fill count never passes the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_entry_count) <= aht_pkg::TABLE_ENTRIES))
        else $error("entry count beyond table size");

endmodule

bind arp_host_table_learner_unit aht_checker u_aht_checker (.*);

[verif/testbench.sv]
// Self-checking testbench for the ARP host table learner against a table predictor.
`timescale 1ns / 1ps

module testbench;
    import aht_pkg::*;

    localparam logic KIND_PACKET  = 1'b0;
    localparam int   POOL_SIZE    = 96;
    localparam int   N_RANDOM     = 1730;
    localparam int   DRAIN_CYCLES = 2 * TABLE_ENTRIES + 16;
    localparam int   CYCLE_LIMIT  = 1500000;
    localparam t_mac MAC_ONES     = '1;
    localparam t_ip  IP_ONES      = '1;

    // Receiver stall behaviors, switched at random intervals.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURST
    } t_stall_mode;

    // Predicts the host table and holds the results still owed by the block.
    class host_table_predictor;
        t_ip    ip_tab[TABLE_ENTRIES];
        t_mac   mac_tab[TABLE_ENTRIES];
        t_flags flag_tab[TABLE_ENTRIES];
        int     fill;
        int     errors;
        t_res   pending_results[$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // First valid slot that holds the address; slot is zero when absent.
        function bit locate(t_ip ip, output int slot);
            int i;
            slot = 0;
            for (i = 0; i < fill; i++) begin
                if (ip_tab[i] == ip) begin
                    slot = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // Appends an entry at the fill point; fails on a full table.
        function bit place(t_ip ip, t_mac mac, t_flags flags, output int slot);
            slot = 0;
            if (fill >= TABLE_ENTRIES) return 1'b0;
            ip_tab[fill]   = ip;
            mac_tab[fill]  = mac;
            flag_tab[fill] = flags;
            slot = fill;
            fill++;
            return 1'b1;
        endfunction

        // Applies one accepted request to the table and queues its result.
        function void absorb_request(logic kind, t_ip sip, t_ip tip, t_mac smac, t_mac tmac,
                                     t_idx ridx);
            t_res res;
            logic grat;
            int   sslot;
            int   tslot;
            int   i;
            bit   s_found;
            bit   t_found;
            bit   s_new;
            bit   t_new;
            bit   full;
            res   = '0;
            s_new = 1'b0;
            t_new = 1'b0;
            full  = 1'b0;
            if (kind == KIND_READ) begin
                if (ridx < fill) begin
                    res.entry_ip    = ip_tab[ridx];
                    res.entry_mac   = mac_tab[ridx];
                    res.entry_flags = flag_tab[ridx];
                end
            end else begin
                grat = (sip == tip) && (tmac == '0);

                // Sender lookup: fill a zero MAC or insert.
                s_found = locate(sip, sslot);
                if (s_found) begin
                    if (mac_tab[sslot] == '0 && smac != '0) mac_tab[sslot] = smac;
                end else begin
                    s_new = place(sip, smac, grat ? FLAG_GRAT : FLAG_SEND, sslot);
                    if (!s_new) full = 1'b1;
                end

                // Target lookup sees the sender entry that may have just been added.
                t_found = locate(tip, tslot);
                if (t_found) begin
                    if (mac_tab[tslot] == '0 && tmac != '0) mac_tab[tslot] = tmac;
                end else begin
                    if (grat) t_new = place(sip, smac, FLAG_GRAT, tslot);
                    else      t_new = place(tip, tmac, FLAG_TARG, tslot);
                    if (!t_new) full = 1'b1;
                end

                // Event flags only when both hosts were known before the packet.
                if (s_found && t_found) begin
                    for (i = 0; i < fill; i++) begin
                        if (ip_tab[i] == sip && grat)  flag_tab[i] |= FLAG_GRAT;
                        else if (ip_tab[i] == sip)     flag_tab[i] |= FLAG_SEND;
                        else if (ip_tab[i] == tip)     flag_tab[i] |= FLAG_TARG;
                    end
                end

                res.sender_slot    = t_oslot'(sslot);
                res.target_slot    = t_oslot'(tslot);
                res.sender_was_new = s_new;
                res.target_was_new = t_new;
                res.entry_added    = s_new || t_new;
                res.table_full     = full;
            end
            res.entry_count = t_ocnt'(fill);
            pending_results = {pending_results, res};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("sender_slot", want.sender_slot, got.sender_slot);
            compare_field("target_slot", want.target_slot, got.target_slot);
            compare_field("sender_was_new", want.sender_was_new, got.sender_was_new);
            compare_field("target_was_new", want.target_was_new, got.target_was_new);
            compare_field("entry_added", want.entry_added, got.entry_added);
            compare_field("table_full", want.table_full, got.table_full);
            compare_field("entry_ip", want.entry_ip, got.entry_ip);
            compare_field("entry_mac", want.entry_mac, got.entry_mac);
            compare_field("entry_gratuitous", want.entry_flags[0], got.entry_flags[0]);
            compare_field("entry_sender_flag", want.entry_flags[1], got.entry_flags[1]);
            compare_field("entry_target_flag", want.entry_flags[2], got.entry_flags[2]);
            compare_field("entry_count", want.entry_count, got.entry_count);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [31:0] i_sender_ip = '0;
    logic [31:0] i_target_ip = '0;
    logic [47:0] i_sender_mac = '0;
    logic [47:0] i_target_mac = '0;
    logic [5:0]  i_read_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [5:0]  o_sender_slot;
    logic [5:0]  o_target_slot;
    logic        o_sender_was_new;
    logic        o_target_was_new;
    logic        o_entry_added;
    logic        o_table_full;
    logic [31:0] o_entry_ip;
    logic [47:0] o_entry_mac;
    logic        o_entry_gratuitous;
    logic        o_entry_sender_flag;
    logic        o_entry_target_flag;
    logic [6:0]  o_entry_count;

    host_table_predictor predictor;
    t_ip                 ip_pool[POOL_SIZE];
    bit                  pacing_on = 1'b0;
    int                  burst_left = 0;
    int unsigned         cycle_count;
    t_stall_mode         stall_mode = STALL_NONE;
    int                  stall_phase_left = 0;
    int                  stall_hold = 0;

    arp_host_table_learner_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_kind              (i_kind),
        .i_sender_ip         (i_sender_ip),
        .i_target_ip         (i_target_ip),
        .i_sender_mac        (i_sender_mac),
        .i_target_mac        (i_target_mac),
        .i_read_index        (i_read_index),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sender_slot       (o_sender_slot),
        .o_target_slot       (o_target_slot),
        .o_sender_was_new    (o_sender_was_new),
        .o_target_was_new    (o_target_was_new),
        .o_entry_added       (o_entry_added),
        .o_table_full        (o_table_full),
        .o_entry_ip          (o_entry_ip),
        .o_entry_mac         (o_entry_mac),
        .o_entry_gratuitous  (o_entry_gratuitous),
        .o_entry_sender_flag (o_entry_sender_flag),
        .o_entry_target_flag (o_entry_target_flag),
        .o_entry_count       (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Presents one request, holds it until accepted, then paces the next in bursts.
    task automatic send_request(input logic kind, input t_ip sip, input t_ip tip,
                                input t_mac smac, input t_mac tmac, input t_idx ridx);
        int gap;
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_sender_ip  <= sip;
        i_target_ip  <= tip;
        i_sender_mac <= smac;
        i_target_mac <= tmac;
        i_read_index <= ridx;
        do @(posedge i_clk); while (o_stall);
        predictor.absorb_request(kind, sip, tip, smac, tmac, ridx);
        if (pacing_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(0, 12);
                gap = $urandom_range(1, 20);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Mostly addresses from a pool that widens over time, rarely a fresh one.
    function automatic t_ip pick_ip(int window);
        if ($urandom_range(0, 199) == 0) return t_ip'($urandom);
        return ip_pool[$urandom_range(0, window - 1)];
    endfunction

    // Zero MACs are common so that later packets can fill them in.
    function automatic t_mac pick_mac();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 7)  return '0;
        if (roll < 9)  return MAC_ONES;
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Result side: check accepted results and stall on a pattern of its own.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.sender_slot    = o_sender_slot;
                got.target_slot    = o_target_slot;
                got.sender_was_new = o_sender_was_new;
                got.target_was_new = o_target_was_new;
                got.entry_added    = o_entry_added;
                got.table_full     = o_table_full;
                got.entry_ip       = o_entry_ip;
                got.entry_mac      = o_entry_mac;
                got.entry_flags    = {o_entry_target_flag, o_entry_sender_flag,
                                      o_entry_gratuitous};
                got.entry_count    = o_entry_count;
                predictor.check_result(got);
            end
            if (stall_phase_left == 0) begin
                stall_mode       = t_stall_mode'($urandom_range(0, 3));
                stall_phase_left = $urandom_range(50, 600);
            end else begin
                stall_phase_left--;
            end
            case (stall_mode)
                STALL_NONE: begin
                    i_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if (stall_hold > 0) begin
                        stall_hold--;
                        i_stall <= 1'b1;
                    end else begin
                        i_stall <= 1'b0;
                        if ($urandom_range(0, 15) == 0) stall_hold = $urandom_range(1, 40);
                    end
                end
            endcase
        end
    end

    // Watchdog on the cycle count.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int   k;
        int   window;
        logic kind;
        t_ip  sip;
        t_ip  tip;
        t_ip  ip_a;
        t_ip  ip_b;
        t_ip  ip_c;
        t_ip  ip_d;
        predictor = new();
        ip_pool[0] = '0;
        ip_pool[1] = IP_ONES;
        for (k = 2; k < POOL_SIZE; k++) ip_pool[k] = t_ip'($urandom);
        ip_a = ip_pool[2];
        ip_b = ip_pool[3];
        ip_c = ip_pool[4];
        ip_d = ip_pool[5];

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests, back to back.
        send_request(KIND_READ, '0, '0, '0, '0, 6'd0);
        // Both hosts new with zero MACs, then both known and MACs filled in.
        send_request(KIND_PACKET, '0, IP_ONES, '0, '0, '0);
        send_request(KIND_READ, '0, '0, '0, '0, 6'd0);
        send_request(KIND_READ, '0, '0, '0, '0, 6'd1);
        send_request(KIND_PACKET, '0, IP_ONES, MAC_ONES, MAC_ONES, '0);
        // Gratuitous announcement of a new host, then of the same host again.
        send_request(KIND_PACKET, ip_a, ip_a, 48'h0000_1234_5678, '0, '0);
        send_request(KIND_PACKET, ip_a, ip_a, 48'hA5A5_5A5A_0F0F, '0, '0);
        // Equal addresses with a target MAC are not gratuitous.
        send_request(KIND_PACKET, ip_b, ip_b, '0, 48'h8000_0000_0001, '0);
        send_request(KIND_PACKET, ip_b, ip_b, 48'h0101_0202_0303, '0, '0);
        // Target entry with a zero MAC, later filled by a sender lookup.
        send_request(KIND_PACKET, ip_c, ip_d, 48'h00C0_FFEE_0001, '0, '0);
        send_request(KIND_PACKET, ip_d, ip_c, 48'h7E57_0000_BEEF, 48'h1111_2222_3333, '0);
        send_request(KIND_PACKET, IP_ONES, ip_d, '0, 48'hFEDC_BA98_7654, 6'h3F);
        for (k = 0; k < 8; k++) send_request(KIND_READ, IP_ONES, IP_ONES, MAC_ONES,
                                             MAC_ONES, t_idx'(k));
        send_request(KIND_READ, '0, '0, '0, '0, 6'd63);

        // Random requests over a slowly widening address pool so the table fills late.
        pacing_on = 1'b1;
        for (k = 0; k < N_RANDOM; k++) begin
            window = 6 + k / 20;
            if (window > POOL_SIZE) window = POOL_SIZE;
            sip  = pick_ip(window);
            tip  = ($urandom_range(0, 99) < 15) ? sip : pick_ip(window);
            kind = ($urandom_range(0, 9) < 3) ? KIND_READ : KIND_PACKET;
            send_request(kind, sip, tip, pick_mac(), pick_mac(), t_idx'($urandom));
        end
        i_valid <= 1'b0;

        // Drain the outstanding results, then give the block time to settle.
        while (predictor.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predictor.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
